@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared constants, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Default sizes of the store.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // Fixed field widths of the configuration and result words.
  localparam int CAP_W  = 5;
  localparam int READ_W = 32;
  localparam int OCC_W  = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } lkv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic latch_match;
    logic apply;
  } lkv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } lkv_sts_t;

endpackage

@@ rtl/lkv_if.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache channels
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Request channel: one get or put operation per word.
interface lkv_req_if #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, output operation, output lookup_key,
                  output write_value, input ready);
  modport sink   (input valid, input operation, input lookup_key,
                  input write_value, output ready);
endinterface

// Response channel: one result word per request.
interface lkv_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lkv_pkg::READ_W-1:0]   read_value;
  logic [lkv_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output hit, output read_value,
                  output occupancy, input ready);
  modport sink   (input valid, input hit, input read_value,
                  input occupancy, output ready);
endinterface

// Configuration channel: writes the active capacity register.
interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkv_pkg::CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each request word is a get or a put and yields exactly one response word
// with the hit flag, the value read on a get hit (zero otherwise) and the
// occupancy after the operation. A request passes through three phases: the
// accept of the word, the key compare that runs across all entries at once,
// and the update of the entry and its recency rank with the load of the
// response register. A new word is accepted only after the last one has been updated. The response
// register lets the next word be accepted while a response waits; the update
// phase only stalls when that register is still full. Configuration writes are
// always accepted and take effect at the next key compare.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);
  import lkv_pkg::*;

  lkv_cmd_t cmd;
  lkv_sts_t sts;
  logic     in_ready;

  // Sequencing of each word.
  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  // Entry store and result register.
  lkv_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (req.operation),
    .in_key         (req.lookup_key),
    .in_value       (req.write_value),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_hit        (rsp.hit),
    .out_read_value (rsp.read_value),
    .out_occupancy  (rsp.occupancy)
  );

endmodule

@@ rtl/lkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache controller
// Steps each accepted word through the compare and update phases and holds
// the update until the result register can take the result.
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lkv_pkg::lkv_sts_t sts,
  output lkv_pkg::lkv_cmd_t cmd
);
  import lkv_pkg::*;

  lkv_state_t state;
  lkv_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready        = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.latch_match = 1'b0;
    cmd.apply       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_MATCH: begin
        cmd.latch_match = 1'b1;
      end
      ST_APPLY: begin
        cmd.apply = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/lkv_datapath.sv @@
// ----------------------------------------------------------------------------
// LRU key/value cache datapath
// Entry keys, values, valid bits and recency ranks, the parallel key compare,
// the rank update and the result register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = lkv_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lkv_pkg::lkv_cmd_t          cmd,
  output lkv_pkg::lkv_sts_t          sts,
  input  logic                       in_operation,
  input  logic [KEY_BITS-1:0]        in_key,
  input  logic [VALUE_BITS-1:0]      in_value,
  input  logic                       cfg_valid,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lkv_pkg::READ_W-1:0] out_read_value,
  output logic [lkv_pkg::OCC_W-1:0]  out_occupancy
);
  import lkv_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Entry storage; keys and values are only read for valid entries.
  logic [KEY_BITS-1:0]   entry_key   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] entry_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [RANK_W-1:0]     recency_rank [MAX_ENTRIES];
  logic [CNT_W-1:0]      entry_count;
  logic [CAP_W-1:0]      active_capacity;

  // Registered request word.
  logic                  op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  // Registered compare outcome.
  logic               hit;
  logic               insert;
  logic               modify;
  logic [IDX_W-1:0]   slot;
  logic [CNT_W-1:0]   rank_top;
  logic [READ_W-1:0]  read_value;

  // Compare-phase signals.
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [IDX_W-1:0]       match_idx;
  logic [RANK_W-1:0]      match_rank;
  logic [VALUE_BITS-1:0]  match_value;
  logic [IDX_W-1:0]       lru_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [RANK_W-1:0]      last_rank;
  logic [CMP_W-1:0]       cap_eff;
  logic [CMP_W-1:0]       cap_raw;
  logic                   need_evict;
  logic                   hit_c;
  logic [CNT_W-1:0]       occ_next;

  // The request word is held for the compare and update phases.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op    <= in_operation;
      key   <= in_key;
      value <= in_value;
    end
  end

  // Capacity register; configuration is always accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      active_capacity <= cfg_data;
    end
  end

  // Effective capacity clamped to the range 1 .. MAX_ENTRIES.
  always_comb begin
    cap_raw = CMP_W'(active_capacity);
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_raw > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_raw;
    end
  end

  // Parallel key compare, least recent entry and lowest free entry.
  // Valid ranks are always 0 .. entry_count-1, so the least recent entry
  // is the valid one whose rank is entry_count-1.
  always_comb begin
    last_rank   = RANK_W'(entry_count - 1'b1);
    match_idx   = '0;
    match_rank  = '0;
    match_value = '0;
    lru_idx     = '0;
    free_idx    = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_key[i] == key);
      if (match_vec[i]) begin
        match_idx   = match_idx | IDX_W'(i);
        match_rank  = match_rank | recency_rank[i];
        match_value = match_value | entry_value[i];
      end
      if (entry_valid[i] && (recency_rank[i] == last_rank)) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) free_idx = IDX_W'(i);
    end
    hit_c      = |match_vec;
    need_evict = CMP_W'(entry_count) >= cap_eff;
  end

  // Latch the compare outcome: target slot and the rank it moves up from.
  always_ff @(posedge clk) begin
    if (cmd.latch_match) begin
      hit        <= hit_c;
      modify     <= hit_c || (op == OP_PUT);
      insert     <= !hit_c && (op == OP_PUT) && !need_evict;
      read_value <= (hit_c && (op == OP_GET)) ? READ_W'(match_value) : '0;
      if (hit_c) begin
        slot     <= match_idx;
        rank_top <= CNT_W'(match_rank);
      end else if (need_evict) begin
        slot     <= lru_idx;
        rank_top <= entry_count - 1'b1;
      end else begin
        slot     <= free_idx;
        rank_top <= entry_count;
      end
    end
  end

  assign occ_next = insert ? (entry_count + 1'b1) : entry_count;

  // Control state of the entries: valid bits, ranks and the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (cmd.apply && modify) begin
      entry_count <= occ_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          recency_rank[i] <= '0;
          if (insert) entry_valid[i] <= 1'b1;
        end else if (entry_valid[i] && (CNT_W'(recency_rank[i]) < rank_top)) begin
          recency_rank[i] <= recency_rank[i] + 1'b1;
        end
      end
    end
  end

  // Entry payload: a put writes the value, a new key also writes the key.
  always_ff @(posedge clk) begin
    if (cmd.apply && (op == OP_PUT)) begin
      entry_value[slot] <= value;
      if (!hit) entry_key[slot] <= key;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_hit        <= hit;
      out_read_value <= read_value;
      out_occupancy  <= OCC_W'(occ_next);
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  // A key is held by at most one valid entry.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("key present in more than one entry");

  // The fill count matches the number of valid entries.
  assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("fill count differs from valid entries");

  // The fill count never exceeds the store size.
  assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= MAX_ENTRIES)
    else $error("fill count above store size");

  // An insert into a free entry raises the fill count by one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.apply && modify && insert |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not raise fill count");

  // The updated entry becomes the most recent one.
  assert property (@(posedge clk) disable iff (rst)
    cmd.apply && modify |=> recency_rank[$past(slot)] == '0)
    else $error("updated entry is not most recent");

endmodule

@@ tb/lru_key_value_cache_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives get and put words against the cache at several capacity settings,
// keeps a shadow copy of the entries and their recency ranks, and compares
// every response word with the predicted hit, read value and occupancy.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int ENTRIES    = MAX_ENTRIES_DEF;
  localparam int KW         = KEY_BITS_DEF;
  localparam int VW         = VALUE_BITS_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_LEN  = 100;
  localparam int LONG_HOLD  = 80;

  typedef struct packed {
    logic              hit;
    logic [READ_W-1:0] read_value;
    logic [OCC_W-1:0]  occupancy;
  } cache_result_t;

  // Shadow store of the cache and the queue of responses still to come.
  class cache_scoreboard;
    logic [KW-1:0]    keys [ENTRIES];
    logic [VW-1:0]    values [ENTRIES];
    logic             used [ENTRIES];
    int               rank [ENTRIES];
    int               count;
    logic [CAP_W-1:0] capacity;
    cache_result_t    expected_q[$];
    int               failures;
    int               hits_seen;
    int               evictions;
    int               peak_occupancy;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
        rank[i] = 0;
      end
      count = 0;
      capacity = CAP_RESET;
      failures = 0;
      hits_seen = 0;
      evictions = 0;
      peak_occupancy = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    // Every valid entry more recent than the slot ages by one.
    function void promote(int slot);
      int r;
      r = rank[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (i != slot && used[i] && rank[i] < r) rank[i]++;
      rank[slot] = 0;
    endfunction

    // Apply one accepted request word and queue the response it causes.
    function void note_request(logic op, logic [KW-1:0] key, logic [VW-1:0] wval);
      int slot;
      int target;
      int cap;
      cache_result_t res;
      slot = -1;
      res = '0;
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && used[i] && keys[i] == key) slot = i;
      if (slot >= 0) begin
        res.hit = 1'b1;
        if (op == OP_PUT) values[slot] = wval;
        else res.read_value = values[slot];
        promote(slot);
      end else if (op == OP_PUT) begin
        // Zero acts as one, anything above the store size as the store size.
        cap = int'(capacity);
        if (cap < 1) cap = 1;
        if (cap > ENTRIES) cap = ENTRIES;
        target = -1;
        if (count < cap)
          for (int i = 0; i < ENTRIES; i++)
            if (target < 0 && !used[i]) target = i;
        if (target >= 0) begin
          used[target] = 1'b1;
          rank[target] = count;
          count++;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (used[i] && (target < 0 || rank[i] > rank[target])) target = i;
          evictions++;
        end
        if (target >= 0) begin
          keys[target] = key;
          values[target] = wval;
          promote(target);
        end
      end
      res.occupancy = OCC_W'(count);
      if (count > peak_occupancy) peak_occupancy = count;
      expected_q.push_back(res);
    endfunction

    // Compare one accepted response word with the oldest expectation.
    function void check_response(cache_result_t got);
      cache_result_t want;
      if (expected_q.size() == 0) begin
        $error("response word with no request outstanding: hit %0d value %h occupancy %0d",
               got.hit, got.read_value, got.occupancy);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.hit) hits_seen++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        failures++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        failures++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkv_req_if req_bus ();
  lkv_rsp_if rsp_bus ();
  lkv_cfg_if cfg_bus ();

  lru_key_value_cache i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  cache_scoreboard sb;
  logic            sender_quiet   = 1'b0;
  logic            receiver_quiet = 1'b0;
  logic            hold_request   = 1'b0;
  int              requests_sent  = 0;
  int              cap_writes     = 0;
  int              idle_cycles    = 0;
  logic [KW-1:0]   key_pool [24];
  int              pool_size;

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every handshake at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready)
        sb.check_response('{rsp_bus.hit, rsp_bus.read_value, rsp_bus.occupancy});
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.operation, req_bus.lookup_key, req_bus.write_value);
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.set_capacity(cfg_bus.data);
        cap_writes++;
      end
    end
  end

  // Give up when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: random stall bursts, plus one long hold when requested.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !receiver_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Random gap on the request side after a word.
  task automatic request_gap();
    if (!sender_quiet && $urandom_range(0, 6) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Offer one request word; called and returns at a falling edge.
  task automatic send_request(input logic op, input logic [KW-1:0] key,
                              input logic [VW-1:0] wval);
    req_bus.valid       <= 1'b1;
    req_bus.operation   <= op;
    req_bus.lookup_key  <= key;
    req_bus.write_value <= wval;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    requests_sent++;
    request_gap();
  endtask

  // Stop offering words until every response has come back.
  task automatic drain_responses();
    req_bus.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  // Capacity writes happen only with the cache idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_responses();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cap;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Fill the key pool so that random traffic hits and evicts often.
  task automatic refill_pool(input int eff_cap);
    pool_size = eff_cap + $urandom_range(1, 6);
    if (pool_size > 24) pool_size = 24;
    for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
    if ($urandom_range(0, 1)) key_pool[0] = '0;
    else key_pool[0] = '1;
  endtask

  // One random word: mostly pooled keys, some fresh ones.
  task automatic send_random();
    logic [KW-1:0] key;
    logic          op;
    if ($urandom_range(0, 4) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, pool_size - 1)];
    op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
    send_request(op, key, $urandom);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    int               eff_cap;
    sb = new();
    req_bus.valid       = 1'b0;
    req_bus.operation   = OP_GET;
    req_bus.lookup_key  = '0;
    req_bus.write_value = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty cache, key and value extremes, put hit, get miss.
    send_request(OP_GET, '0, '0);
    send_request(OP_PUT, '0, '0);
    send_request(OP_PUT, '1, '1);
    send_request(OP_GET, '0, '1);
    send_request(OP_GET, '1, '0);
    send_request(OP_PUT, '0, 32'hA5A5_A5A5);
    send_request(OP_GET, '0, '0);
    send_request(OP_GET, 32'h1234_5678, '0);
    for (int i = 1; i <= 4; i++) send_request(OP_PUT, KW'(i), 32'h5A5A_0000 + VW'(i));

    // Capacity zero behaves as one and sits below the occupancy: a new key
    // replaces the least recent entry and the occupancy holds.
    write_capacity(CAP_W'(0));
    send_request(OP_PUT, 32'h8000_0000, 32'h0000_0001);
    send_request(OP_GET, '1, '0);
    send_request(OP_GET, 32'h8000_0000, '0);

    // Oversized capacity behaves as the full store.
    write_capacity(CAP_W'(31));
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_GET, 32'h7FFF_FFFF, '0);

    // Small capacity with a recency reorder before the eviction.
    write_capacity(CAP_W'(2));
    send_request(OP_GET, KW'(1), '0);
    send_request(OP_PUT, 32'hDEAD_BEEF, 32'hFFFF_0000);
    send_request(OP_PUT, 32'hCAFE_F00D, 32'h0000_FFFF);
    send_request(OP_GET, KW'(1), '0);
    send_request(OP_GET, 32'hDEAD_BEEF, '0);

    // Random phases, each at its own capacity.
    phase_caps = '{CAP_W'(16), CAP_W'(1), CAP_W'(4), CAP_W'(31), CAP_W'(0),
                   CAP_W'(8), CAP_W'(3), CAP_W'(17), CAP_W'(0), CAP_W'(16)};
    phase_caps[8] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      eff_cap = int'(phase_caps[p]);
      if (eff_cap < 1) eff_cap = 1;
      if (eff_cap > ENTRIES) eff_cap = ENTRIES;
      refill_pool(eff_cap);
      sender_quiet   = (p == 2 || p == 4 || p == 9);
      receiver_quiet = (p == 2 || p == 9);
      // Back up the response side while requests keep coming.
      if (p == 4) hold_request = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 4 && n == 40) sender_quiet = 1'b0;
        if (p == 6 && n == 50) drain_responses();
        send_random();
      end
    end

    drain_responses();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests (%0d hits, %0d evictions) over %0d capacity writes.",
             requests_sent, sb.hits_seen, sb.evictions, cap_writes);
    $display("Peak occupancy was %0d of %0d entries.", sb.peak_occupancy, ENTRIES);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
